@@ rtl/pli_pkg.sv @@
package pli_pkg;

   // Default list depth; the top level hands its own value down.
   localparam int CAPACITY_DEF = 16;

   localparam int ACTION_W   = 2;
   localparam int POSITION_W = 8;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 2;

   // Request kinds carried on req_tuser.
   localparam logic [ACTION_W-1:0] ACT_INSERT  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DELETE  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_READOUT = 2'd2;

   // Result status codes carried on rsp_tuser.
   localparam logic [STATUS_W-1:0] STS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STS_BADPOS = 2'd1;
   localparam logic [STATUS_W-1:0] STS_FULL   = 2'd2;
   localparam logic [STATUS_W-1:0] STS_EMPTY  = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_SHIFT,
      ST_INS_DRAIN,
      ST_INS_WRITE,
      ST_DEL_SHIFT,
      ST_DEL_DRAIN,
      ST_RO_EMIT,
      ST_DONE
   } state_type;

endpackage

@@ rtl/pli_ram.sv @@
module pli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wen,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             ren,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wen) begin
         mem_ff[waddr] <= wdata;
      end
      // Hold read data until the next read.
      if (ren) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/pli_idx_unit.sv @@
module pli_idx_unit #(
   parameter int AW = 4
) (
   input  logic [AW-1:0] idx,
   input  logic [AW-1:0] limit,
   input  logic          down,
   output logic [AW-1:0] step,
   output logic [AW-1:0] back,
   output logic          hit
);

   // Walk one slot along the list, and give the slot just behind.
   always_comb begin
      if (down) begin
         step = idx - AW'(1);
         back = idx + AW'(1);
      end else begin
         step = idx + AW'(1);
         back = idx - AW'(1);
      end
      hit = (idx == limit);
   end

endmodule

@@ rtl/pli_engine.sv @@
module pli_engine #(
   parameter int CAPACITY = pli_pkg::CAPACITY_DEF,
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   localparam int CW = $clog2(CAPACITY + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [pli_pkg::ACTION_W-1:0]      req_action,
   input  logic [pli_pkg::POSITION_W-1:0]    req_position,
   input  logic signed [pli_pkg::VALUE_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [pli_pkg::STATUS_W-1:0]      rsp_status,
   output logic signed [pli_pkg::VALUE_W-1:0] rsp_value,
   output logic                              rsp_last,
   output logic                              ram_wen,
   output logic [AW-1:0]                     ram_waddr,
   output logic [pli_pkg::VALUE_W-1:0]       ram_wdata,
   output logic                              ram_ren,
   output logic [AW-1:0]                     ram_raddr,
   input  logic [pli_pkg::VALUE_W-1:0]       ram_rdata
);

   pli_pkg::state_type state_ff, state_in;

   logic [CW-1:0]                     count_ff, count_in;
   logic [AW-1:0]                     ridx_ff, ridx_in;
   logic [AW-1:0]                     limit_ff, limit_in;
   logic [AW-1:0]                     waddr_ff, waddr_in;
   logic                              pend_ff, pend_in;
   logic                              cap_ff, cap_in;
   logic                              first_ff, first_in;
   logic [pli_pkg::VALUE_W-1:0]       ival_ff, ival_in;
   logic [pli_pkg::STATUS_W-1:0]      rstatus_ff, rstatus_in;
   logic [pli_pkg::VALUE_W-1:0]       rval_ff, rval_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [pli_pkg::STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [pli_pkg::VALUE_W-1:0]       rsp_value_ff, rsp_value_in;
   logic                              rsp_last_ff, rsp_last_in;

   logic                              accept;
   logic                              slot_free;
   logic [8:0]                        pos9;
   logic [8:0]                        cnt9;
   logic [pli_pkg::POSITION_W-1:0]    pos_m1;
   logic [CW-1:0]                     count_m1;
   logic                              ins_ok;
   logic                              del_ok;
   logic                              full;
   logic                              idx_down;
   logic [AW-1:0]                     idx_step;
   logic [AW-1:0]                     idx_back;
   logic                              idx_hit;

   assign accept    = req_valid && (state_ff == pli_pkg::ST_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign pos9      = {1'b0, req_position};
   assign cnt9      = 9'(count_ff);
   assign pos_m1    = req_position - 8'd1;
   assign count_m1  = count_ff - CW'(1);
   assign ins_ok    = (req_position != '0) && (pos9 <= cnt9 + 9'd1);
   assign del_ok    = (req_position != '0) && (pos9 <= cnt9);
   assign full      = (count_ff == CW'(CAPACITY));
   assign idx_down  = (state_ff == pli_pkg::ST_INS_SHIFT);

   pli_idx_unit #(.AW(AW)) u_idx (
      .idx   (ridx_ff),
      .limit (limit_ff),
      .down  (idx_down),
      .step  (idx_step),
      .back  (idx_back),
      .hit   (idx_hit)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pli_pkg::ST_IDLE: begin
            if (req_valid) begin
               priority case (req_action)
                  pli_pkg::ACT_INSERT: begin
                     if (!ins_ok || full) begin
                        state_in = pli_pkg::ST_DONE;
                     end else if (pos9 <= cnt9) begin
                        state_in = pli_pkg::ST_INS_SHIFT;
                     end else begin
                        state_in = pli_pkg::ST_INS_WRITE;
                     end
                  end
                  pli_pkg::ACT_DELETE: begin
                     state_in = del_ok ? pli_pkg::ST_DEL_SHIFT : pli_pkg::ST_DONE;
                  end
                  pli_pkg::ACT_READOUT: begin
                     state_in = (count_ff == '0) ? pli_pkg::ST_DONE : pli_pkg::ST_RO_EMIT;
                  end
                  default: begin
                     state_in = pli_pkg::ST_DONE;
                  end
               endcase
            end
         end
         pli_pkg::ST_INS_SHIFT: begin
            if (idx_hit) begin
               state_in = pli_pkg::ST_INS_DRAIN;
            end
         end
         pli_pkg::ST_INS_DRAIN: begin
            state_in = pli_pkg::ST_INS_WRITE;
         end
         pli_pkg::ST_INS_WRITE: begin
            state_in = pli_pkg::ST_DONE;
         end
         pli_pkg::ST_DEL_SHIFT: begin
            if (idx_hit) begin
               state_in = pli_pkg::ST_DEL_DRAIN;
            end
         end
         pli_pkg::ST_DEL_DRAIN: begin
            state_in = pli_pkg::ST_DONE;
         end
         pli_pkg::ST_RO_EMIT: begin
            if (slot_free && idx_hit) begin
               state_in = pli_pkg::ST_IDLE;
            end
         end
         pli_pkg::ST_DONE: begin
            if (slot_free) begin
               state_in = pli_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pli_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath controls and register next values.
   always_comb begin
      count_in      = count_ff;
      ridx_in       = ridx_ff;
      limit_in      = limit_ff;
      waddr_in      = waddr_ff;
      pend_in       = pend_ff;
      cap_in        = cap_ff;
      first_in      = first_ff;
      ival_in       = ival_ff;
      rstatus_in    = rstatus_ff;
      rval_in       = rval_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      ram_wen       = 1'b0;
      ram_waddr     = waddr_ff;
      ram_wdata     = ram_rdata;
      ram_ren       = 1'b0;
      ram_raddr     = ridx_ff;

      unique case (state_ff)
         pli_pkg::ST_IDLE: begin
            if (accept) begin
               ival_in  = req_value;
               rval_in  = '0;
               pend_in  = 1'b0;
               first_in = 1'b1;
               priority case (req_action)
                  pli_pkg::ACT_INSERT: begin
                     ridx_in  = count_m1[AW-1:0];
                     limit_in = pos_m1[AW-1:0];
                     if (!ins_ok) begin
                        rstatus_in = pli_pkg::STS_BADPOS;
                     end else if (full) begin
                        rstatus_in = pli_pkg::STS_FULL;
                     end else begin
                        rstatus_in = pli_pkg::STS_OK;
                     end
                  end
                  pli_pkg::ACT_DELETE: begin
                     ridx_in    = pos_m1[AW-1:0];
                     limit_in   = count_m1[AW-1:0];
                     rstatus_in = del_ok ? pli_pkg::STS_OK : pli_pkg::STS_BADPOS;
                  end
                  pli_pkg::ACT_READOUT: begin
                     ridx_in    = '0;
                     limit_in   = count_m1[AW-1:0];
                     ram_ren    = 1'b1;
                     ram_raddr  = '0;
                     rstatus_in = (count_ff == '0) ? pli_pkg::STS_EMPTY : pli_pkg::STS_OK;
                  end
                  default: begin
                     rstatus_in = pli_pkg::STS_BADPOS;
                  end
               endcase
            end
         end
         pli_pkg::ST_INS_SHIFT: begin
            // Read slot k, write it to slot k+1 in the cycle after.
            ram_ren  = 1'b1;
            ram_wen  = pend_ff;
            pend_in  = 1'b1;
            waddr_in = idx_back;
            ridx_in  = idx_step;
         end
         pli_pkg::ST_INS_DRAIN: begin
            ram_wen = 1'b1;
         end
         pli_pkg::ST_INS_WRITE: begin
            ram_wen   = 1'b1;
            ram_waddr = limit_ff;
            ram_wdata = ival_ff;
            count_in  = CW'(count_ff + 1'b1);
         end
         pli_pkg::ST_DEL_SHIFT: begin
            // The first slot read is the one removed; later ones move down.
            ram_ren  = 1'b1;
            pend_in  = 1'b1;
            cap_in   = first_ff;
            first_in = 1'b0;
            waddr_in = idx_back;
            ridx_in  = idx_step;
            if (pend_ff) begin
               if (cap_ff) begin
                  rval_in = ram_rdata;
               end else begin
                  ram_wen = 1'b1;
               end
            end
         end
         pli_pkg::ST_DEL_DRAIN: begin
            if (cap_ff) begin
               rval_in = ram_rdata;
            end else begin
               ram_wen = 1'b1;
            end
            count_in = count_m1;
         end
         pli_pkg::ST_RO_EMIT: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pli_pkg::STS_OK;
               rsp_value_in  = ram_rdata;
               rsp_last_in   = idx_hit;
               if (!idx_hit) begin
                  ram_ren   = 1'b1;
                  ram_raddr = idx_step;
                  ridx_in   = idx_step;
               end
            end
         end
         pli_pkg::ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = rstatus_ff;
               rsp_value_in  = rval_ff;
               rsp_last_in   = 1'b1;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp_ready;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pli_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         cap_ff       <= 1'b0;
         first_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         cap_ff       <= cap_in;
         first_ff     <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      ridx_ff       <= ridx_in;
      limit_ff      <= limit_in;
      waddr_ff      <= waddr_in;
      ival_ff       <= ival_in;
      rstatus_ff    <= rstatus_in;
      rval_ff       <= rval_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_ready  = (state_ff == pli_pkg::ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_last   = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pli_pkg::ST_INS_WRITE) |=> (count_ff == CW'($past(count_ff) + 1'b1)))
      else $error("insert did not grow the list by one");

   a_write_range: assert property (@(posedge clock) disable iff (reset)
      ram_wen |-> (32'(ram_waddr) < 32'(CAPACITY)))
      else $error("store write beyond capacity");

   a_readout_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pli_pkg::ST_RO_EMIT) |-> !ram_wen)
      else $error("store written during read-out");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != pli_pkg::ST_IDLE))
      else $error("accepted transaction left no work");

endmodule

@@ rtl/positional_list_insert_delete_top.sv @@
// Channel  Dir  tdata (low bit up)                 tuser       tlast
// req_     in   position[7:0], item_value[39:8]    action[1:0] -
// rsp_     out  result_value[31:0]                 status[1:0] last
//
// One transaction is taken at a time; req_tready is high only while idle.
// Insert at the tail writes and answers; insert with a shift, and delete, walk
// the entries first; read-out emits each entry; errors answer directly. The store
// port pair and shared index stepper pace the shift, one entry per cycle.
// Reset clears the entry count; the store itself is never cleared.
// A stalled rsp_ holds the engine at its next result, not the list.
module positional_list_insert_delete_top #(
   parameter int CAPACITY = pli_pkg::CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // position[7:0], item_value[39:8]
   input  logic [1:0]  req_tuser,   // action[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // result_value[31:0]
   output logic [1:0]  rsp_tuser,   // status[1:0]
   output logic        rsp_tlast
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   // Store port wiring between the engine and the entry memory.
   logic                          ram_wen;
   logic [AW-1:0]                 ram_waddr;
   logic [pli_pkg::VALUE_W-1:0]   ram_wdata;
   logic                          ram_ren;
   logic [AW-1:0]                 ram_raddr;
   logic [pli_pkg::VALUE_W-1:0]   ram_rdata;

   // Unpack the request transaction.
   logic [pli_pkg::POSITION_W-1:0]     req_position;
   logic signed [pli_pkg::VALUE_W-1:0] req_value;
   logic signed [pli_pkg::VALUE_W-1:0] rsp_value;

   assign req_position = req_tdata[7:0];
   assign req_value    = req_tdata[39:8];
   assign rsp_tdata    = rsp_value;

   pli_ram #(
      .WIDTH (pli_pkg::VALUE_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock (clock),
      .wen   (ram_wen),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .ren   (ram_ren),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Sequencer: validates the request, walks the shift, emits results.
   pli_engine #(
      .CAPACITY (CAPACITY)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_action   (req_tuser),
      .req_position (req_position),
      .req_value    (req_value),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_status   (rsp_tuser),
      .rsp_value    (rsp_value),
      .rsp_last     (rsp_tlast),
      .ram_wen      (ram_wen),
      .ram_waddr    (ram_waddr),
      .ram_wdata    (ram_wdata),
      .ram_ren      (ram_ren),
      .ram_raddr    (ram_raddr),
      .ram_rdata    (ram_rdata)
   );

endmodule
